// ----- rtl/suid_pkg.sv -----
// Package for the set union / intersection / difference block: types, sizes and codes.
`timescale 1ns / 1ps
package suid_pkg;

  // Store geometry
  localparam int DEPTH  = 32;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ELEM_W = 32;
  localparam int KIND_W = 3;
  localparam int RCNT_W = 7;

  // Item kind codes
  localparam logic [KIND_W-1:0] KIND_LOAD_A = 3'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_B = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UNION  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_INTER  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DIFF   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 3'd5;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [ELEM_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [ELEM_W-1:0] element;
    logic                     last;
    logic                     result_empty;
    logic [RCNT_W-1:0]        result_count;
    logic                     dropped;
  } out_item_t;

  // Write and read request to one store memory
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [ELEM_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr;
  } ram_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_FETCH,
    ST_WAIT,
    ST_SCAN,
    ST_DECIDE,
    ST_FINISH
  } state_t;

endpackage

// ----- rtl/suid_ram.sv -----
// Generic single-write, single-read memory with registered read data.
`timescale 1ns / 1ps
module suid_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/suid_outbuf.sv -----
// Output register: holds one result transaction while downstream stalls.
`timescale 1ns / 1ps
module suid_outbuf import suid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      emit,
  input  out_item_t emit_item,
  output logic      free,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  assign free = !result_valid || !result_stall;

  // Load a new transaction or drain the taken one
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  // Payload has no reset
  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_item;
    end
  end

endmodule

// ----- rtl/suid_ctrl.sv -----
// Sequencer: loads the stores, scans them for each candidate and forms the result stream.
`timescale 1ns / 1ps
module suid_ctrl import suid_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  in_item_t          item,
  output ram_req_t          a_req,
  input  logic [ELEM_W-1:0] a_rdata,
  output ram_req_t          b_req,
  input  logic [ELEM_W-1:0] b_rdata,
  output logic              emit,
  output out_item_t         emit_item,
  input  logic              out_free
);

  localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

  state_t            state, state_next;
  logic [KIND_W-1:0] op, op_next;
  logic              phase_b, phase_b_next;
  logic [CNT_W-1:0]  a_count, a_count_next;
  logic [CNT_W-1:0]  b_count, b_count_next;
  logic              overflow_seen, overflow_seen_next;
  logic [CNT_W-1:0]  i, i_next;
  logic [CNT_W-1:0]  j, j_next;
  logic              rd_v, rd_v_next;
  logic [CNT_W-1:0]  rd_j, rd_j_next;
  logic [ELEM_W-1:0] cand, cand_next;
  logic              a_hit, a_hit_next;
  logic              b_hit, b_hit_next;
  logic              have_pend, have_pend_next;
  logic [ELEM_W-1:0] pend, pend_next;
  logic [RCNT_W-1:0] n, n_next;

  logic [CNT_W-1:0]  limit_a, limit_b, scan_len;
  logic              keep;

  // Phase A: A hit means an earlier copy in A, B hit means membership in B.
  // Phase B: A hit means membership in A, B hit means an earlier copy in B.
  assign limit_a  = phase_b ? a_count : i;
  assign limit_b  = phase_b ? i : b_count;
  assign scan_len = (limit_a > limit_b) ? limit_a : limit_b;

  always_comb begin
    if (phase_b) begin
      keep = !a_hit && !b_hit;
    end else begin
      keep = !a_hit && ((op == KIND_UNION) || ((op == KIND_INTER) && b_hit) ||
                        ((op == KIND_DIFF) && !b_hit));
    end
  end

  // Next state and outputs
  always_comb begin
    state_next         = state;
    op_next            = op;
    phase_b_next       = phase_b;
    a_count_next       = a_count;
    b_count_next       = b_count;
    overflow_seen_next = overflow_seen;
    i_next             = i;
    j_next             = j;
    rd_v_next          = rd_v;
    rd_j_next          = rd_j;
    cand_next          = cand;
    a_hit_next         = a_hit;
    b_hit_next         = b_hit;
    have_pend_next     = have_pend;
    pend_next          = pend;
    n_next             = n;

    item_stall = (state != ST_IDLE);
    a_req      = '0;
    b_req      = '0;
    a_req.wdata = item.value;
    b_req.wdata = item.value;
    a_req.waddr = a_count[IDX_W-1:0];
    b_req.waddr = b_count[IDX_W-1:0];
    emit       = 1'b0;
    emit_item  = '0;
    emit_item.element = pend;
    emit_item.dropped = overflow_seen;

    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          case (item.kind) inside
            KIND_LOAD_A: begin
              if (a_count < FULL) begin
                a_req.we     = 1'b1;
                a_count_next = a_count + 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            KIND_LOAD_B: begin
              if (b_count < FULL) begin
                b_req.we     = 1'b1;
                b_count_next = b_count + 1'b1;
              end else begin
                overflow_seen_next = 1'b1;
              end
            end
            KIND_UNION, KIND_INTER, KIND_DIFF: begin
              op_next        = item.kind;
              phase_b_next   = 1'b0;
              i_next         = '0;
              n_next         = '0;
              have_pend_next = 1'b0;
              state_next     = ST_CHECK;
            end
            KIND_CLEAR: begin
              a_count_next = '0;
              b_count_next = '0;
            end
            default: ;
          endcase
        end
      end

      // Advance to the next candidate or the next phase
      ST_CHECK: begin
        if (!phase_b) begin
          if (i == a_count) begin
            if (op == KIND_UNION) begin
              phase_b_next = 1'b1;
              i_next       = '0;
            end else begin
              state_next = ST_FINISH;
            end
          end else begin
            state_next = ST_FETCH;
          end
        end else if (i == b_count) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FETCH;
        end
      end

      ST_FETCH: begin
        a_req.raddr = i[IDX_W-1:0];
        b_req.raddr = i[IDX_W-1:0];
        j_next      = '0;
        rd_v_next   = 1'b0;
        a_hit_next  = 1'b0;
        b_hit_next  = 1'b0;
        state_next  = ST_WAIT;
      end

      ST_WAIT: begin
        cand_next  = phase_b ? b_rdata : a_rdata;
        state_next = ST_SCAN;
      end

      // Read one entry of each store a cycle; compare the data in the following cycle
      ST_SCAN: begin
        if (rd_v) begin
          if ((rd_j < limit_a) && (a_rdata == cand)) begin
            a_hit_next = 1'b1;
          end
          if ((rd_j < limit_b) && (b_rdata == cand)) begin
            b_hit_next = 1'b1;
          end
        end
        if (j < scan_len) begin
          a_req.raddr = j[IDX_W-1:0];
          b_req.raddr = j[IDX_W-1:0];
          rd_v_next   = 1'b1;
          rd_j_next   = j;
          j_next      = j + 1'b1;
        end else begin
          rd_v_next = 1'b0;
          if (!rd_v) begin
            state_next = ST_DECIDE;
          end
        end
      end

      // Keep the candidate if it qualifies; push out the element held before it
      ST_DECIDE: begin
        if (!(keep && have_pend && !out_free)) begin
          if (keep) begin
            emit           = have_pend;
            pend_next      = cand;
            have_pend_next = 1'b1;
            n_next         = n + 1'b1;
          end
          i_next     = i + 1'b1;
          state_next = ST_CHECK;
        end
      end

      // Send the final transaction, or the empty marker
      ST_FINISH: begin
        if (out_free) begin
          emit                   = 1'b1;
          emit_item.last         = 1'b1;
          emit_item.result_empty = !have_pend;
          emit_item.result_count = have_pend ? n : '0;
          if (!have_pend) begin
            emit_item.element = '0;
          end
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      a_count       <= '0;
      b_count       <= '0;
      overflow_seen <= 1'b0;
      rd_v          <= 1'b0;
      have_pend     <= 1'b0;
    end else begin
      a_count       <= a_count_next;
      b_count       <= b_count_next;
      overflow_seen <= overflow_seen_next;
      rd_v          <= rd_v_next;
      have_pend     <= have_pend_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    op      <= op_next;
    phase_b <= phase_b_next;
    i       <= i_next;
    j       <= j_next;
    rd_j    <= rd_j_next;
    cand    <= cand_next;
    a_hit   <= a_hit_next;
    b_hit   <= b_hit_next;
    pend    <= pend_next;
    n       <= n_next;
  end

  // Store counts never pass the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (a_count <= FULL) && (b_count <= FULL))
    else $error("store count beyond depth");

  // A transaction is handed over only when the output register can take it
  emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> out_free)
    else $error("emit while output register busy");

  // The empty marker goes out only when no element was collected
  empty_only_without_elem: assert property (@(posedge clk) disable iff (rst)
    (emit && emit_item.result_empty) |-> (!have_pend && emit_item.last))
    else $error("empty marker with collected elements");

  // Result size never exceeds the two stores together
  count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> ({1'b0, n} <= (RCNT_W + 1)'(a_count) + (RCNT_W + 1)'(b_count)))
    else $error("result count beyond store contents");

  // A load never disturbs the stores while a compute is underway
  no_write_in_compute: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |=> $stable(a_count) && $stable(b_count))
    else $error("store changed during compute");

endmodule

// ----- rtl/set_union_intersect_diff.sv -----
// Top level of the set union / intersection / difference block.
// Two stores of up to DEPTH (32) signed 32-bit values, A and B. A load or clear
// transaction is taken in the idle state without holding off input. A union,
// intersection or difference transaction holds off further input until its last
// result is handed to the output register: for every candidate element (each entry
// of A, then for union each entry of B) the sequencer checks, fetches and waits for
// it, reads up to max(position, other store count) entries of both store memories
// one entry a cycle through their single read ports, then decides on it. A compute
// also waits when it must hand a result on while the output register is full.
// Results follow the store order of first occurrence; the last one carries the count,
// and an empty result is one transaction marked empty. A full store drops further
// loads and sets the sticky dropped flag, which only reset clears. The stores need no
// clearing pass after reset.
`timescale 1ns / 1ps
module set_union_intersect_diff import suid_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_stall,
  input  in_item_t  item,
  output logic      result_valid,
  input  logic      result_stall,
  output out_item_t result
);

  ram_req_t          a_req, b_req;
  logic [ELEM_W-1:0] a_rdata, b_rdata;
  logic              emit, out_free;
  out_item_t         emit_item;

  // Store A
  suid_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_a (
    .clk   (clk),
    .we    (a_req.we),
    .waddr (a_req.waddr),
    .wdata (a_req.wdata),
    .raddr (a_req.raddr),
    .rdata (a_rdata)
  );

  // Store B
  suid_ram #(.WIDTH(ELEM_W), .DEPTH(DEPTH)) u_store_b (
    .clk   (clk),
    .we    (b_req.we),
    .waddr (b_req.waddr),
    .wdata (b_req.wdata),
    .raddr (b_req.raddr),
    .rdata (b_rdata)
  );

  suid_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .a_req      (a_req),
    .a_rdata    (a_rdata),
    .b_req      (b_req),
    .b_rdata    (b_rdata),
    .emit       (emit),
    .emit_item  (emit_item),
    .out_free   (out_free)
  );

  suid_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .emit         (emit),
    .emit_item    (emit_item),
    .free         (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
